FILE: rtl/core/assert_macros.svh
// Assertion helpers for the frame parser checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define PSFP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check on every clock edge, reset included.
`define PSFP_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/psfp_pkg.sv
package psfp_pkg;

	localparam int FRAME_BYTES  = 32;
	localparam int POS_W        = $clog2(FRAME_BYTES);
	localparam int LEN_OVERHEAD = 4;

	localparam logic [7:0] HDR_FIRST  = 8'h42;
	localparam logic [7:0] HDR_SECOND = 8'h4D;

	localparam logic [15:0] LEN_EXPECT = 16'(FRAME_BYTES - LEN_OVERHEAD);

	localparam logic [POS_W-1:0] POS_HDR0    = POS_W'(0);
	localparam logic [POS_W-1:0] POS_HDR1    = POS_W'(1);
	localparam logic [POS_W-1:0] POS_LEN_HI  = POS_W'(2);
	localparam logic [POS_W-1:0] POS_LEN_LO  = POS_W'(3);
	localparam logic [POS_W-1:0] POS_PM1_HI  = POS_W'(4);
	localparam logic [POS_W-1:0] POS_PM1_LO  = POS_W'(5);
	localparam logic [POS_W-1:0] POS_PM25_HI = POS_W'(6);
	localparam logic [POS_W-1:0] POS_PM25_LO = POS_W'(7);
	localparam logic [POS_W-1:0] POS_PM10_HI = POS_W'(8);
	localparam logic [POS_W-1:0] POS_PM10_LO = POS_W'(9);
	localparam logic [POS_W-1:0] POS_CSUM_HI = POS_W'(FRAME_BYTES - 2);
	localparam logic [POS_W-1:0] POS_LAST    = POS_W'(FRAME_BYTES - 1);

	localparam logic [1:0] STATUS_OK         = 2'd0;
	localparam logic [1:0] STATUS_BAD_HEADER = 2'd1;
	localparam logic [1:0] STATUS_BAD_LENGTH = 2'd2;
	localparam logic [1:0] STATUS_BAD_CSUM   = 2'd3;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       first_byte;
	} item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] pm1_value;
		logic [15:0] pm25_value;
		logic [15:0] pm10_value;
	} result_t;

endpackage

FILE: rtl/core/psfp_in_stage.sv
module psfp_in_stage (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  psfp_pkg::item_t in_item,
	input  logic            take,
	output logic            item_valid_s1,
	output psfp_pkg::item_t item_s1
);

	logic load;

	assign in_stall = item_valid_s1 && !take;
	assign load     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (take || !item_valid_s1) begin
			item_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= in_item;
		end
	end

endmodule

FILE: rtl/core/psfp_frame_track.sv
module psfp_frame_track (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  psfp_pkg::item_t   item,
	input  logic              out_free,
	output logic              take,
	output logic              res_valid,
	output psfp_pkg::result_t res
);

	logic [psfp_pkg::POS_W-1:0] pos_q;
	logic [psfp_pkg::POS_W-1:0] p;
	logic [15:0]                sum_q;
	logic [15:0]                sum_base;
	logic [15:0]                sum_next;
	logic                       hdr_bad_q;
	logic                       len_bad_q;
	logic [7:0]                 len_hi_q;
	logic [7:0]                 csum_hi_q;
	logic [15:0]                pm1_q;
	logic [15:0]                pm25_q;
	logic [15:0]                pm10_q;
	logic                       is_last;
	logic [7:0]                 b;
	logic [1:0]                 status;

	assign b       = item.byte_value;
	assign p       = item.first_byte ? psfp_pkg::POS_HDR0 : pos_q;
	assign is_last = (p == psfp_pkg::POS_LAST);

	assign take      = item_valid && (!is_last || out_free);
	assign res_valid = item_valid && is_last && out_free;

	assign sum_base = (p == psfp_pkg::POS_HDR0) ? 16'h0000 : sum_q;
	assign sum_next = sum_base + ((p < psfp_pkg::POS_CSUM_HI) ? {8'h00, b} : 16'h0000);

	always_comb begin
		if (hdr_bad_q) begin
			status = psfp_pkg::STATUS_BAD_HEADER;
		end else if (len_bad_q) begin
			status = psfp_pkg::STATUS_BAD_LENGTH;
		end else if ({csum_hi_q, b} != sum_q) begin
			status = psfp_pkg::STATUS_BAD_CSUM;
		end else begin
			status = psfp_pkg::STATUS_OK;
		end
		res.status     = status;
		res.pm1_value  = (status == psfp_pkg::STATUS_OK) ? pm1_q : 16'h0000;
		res.pm25_value = (status == psfp_pkg::STATUS_OK) ? pm25_q : 16'h0000;
		res.pm10_value = (status == psfp_pkg::STATUS_OK) ? pm10_q : 16'h0000;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			sum_q     <= 16'h0000;
			hdr_bad_q <= 1'b0;
			len_bad_q <= 1'b0;
		end else if (take) begin
			pos_q <= is_last ? psfp_pkg::POS_HDR0 : p + psfp_pkg::POS_W'(1);
			sum_q <= sum_next;
			if (p == psfp_pkg::POS_HDR0) begin
				hdr_bad_q <= (b != psfp_pkg::HDR_FIRST);
				len_bad_q <= 1'b0;
			end else if (p == psfp_pkg::POS_HDR1) begin
				hdr_bad_q <= hdr_bad_q || (b != psfp_pkg::HDR_SECOND);
			end else if (p == psfp_pkg::POS_LEN_LO) begin
				len_bad_q <= ({len_hi_q, b} != psfp_pkg::LEN_EXPECT);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			case (p)
				psfp_pkg::POS_LEN_HI:  len_hi_q     <= b;
				psfp_pkg::POS_PM1_HI:  pm1_q[15:8]  <= b;
				psfp_pkg::POS_PM1_LO:  pm1_q[7:0]   <= b;
				psfp_pkg::POS_PM25_HI: pm25_q[15:8] <= b;
				psfp_pkg::POS_PM25_LO: pm25_q[7:0]  <= b;
				psfp_pkg::POS_PM10_HI: pm10_q[15:8] <= b;
				psfp_pkg::POS_PM10_LO: pm10_q[7:0]  <= b;
				psfp_pkg::POS_CSUM_HI: csum_hi_q    <= b;
				default: ;
			endcase
		end
	end

endmodule

FILE: rtl/core/psfp_out_stage.sv
module psfp_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              res_valid,
	input  psfp_pkg::result_t res,
	output logic              out_free,
	output logic              out_valid,
	input  logic              out_stall,
	output psfp_pkg::result_t out_res
);

	logic              out_valid_q;
	psfp_pkg::result_t res_q;

	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			res_q <= res;
		end
	end

endmodule

FILE: rtl/core/particulate_sensor_frame_parser.sv
// Parses fixed-length particulate sensor frames, one byte per transfer. A byte with first_byte
// set restarts the frame; otherwise frames follow each other back to back. After the last byte
// of a frame one result carries a status (ok, bad header, bad length field, checksum mismatch,
// first failure wins) and the PM1.0, PM2.5 and PM10 words, which read as zero when the status
// is not ok. A byte is taken in every cycle unless the input stalls; the result of a frame
// reaches the output through an input register and a result register. Input stalls only
// while the result register is full and stalled and the held byte ends a frame.
`include "assert_macros.svh"

module particulate_sensor_frame_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  byte_value,
	input  logic        first_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [15:0] pm1_value,
	output logic [15:0] pm25_value,
	output logic [15:0] pm10_value
);

	psfp_pkg::item_t   in_item;
	psfp_pkg::item_t   item_s1;
	logic              item_valid_s1;
	logic              take;
	logic              out_free;
	logic              res_valid;
	psfp_pkg::result_t res;
	psfp_pkg::result_t out_res;

	assign in_item.byte_value = byte_value;
	assign in_item.first_byte = first_byte;

	psfp_in_stage u_in_stage (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.in_item       (in_item),
		.take          (take),
		.item_valid_s1 (item_valid_s1),
		.item_s1       (item_s1)
	);

	psfp_frame_track u_frame_track (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid_s1),
		.item       (item_s1),
		.out_free   (out_free),
		.take       (take),
		.res_valid  (res_valid),
		.res        (res)
	);

	psfp_out_stage u_out_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.out_free  (out_free),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_res   (out_res)
	);

	assign status     = out_res.status;
	assign pm1_value  = out_res.pm1_value;
	assign pm25_value = out_res.pm25_value;
	assign pm10_value = out_res.pm10_value;

	`PSFP_ASSERT(a_res_only_when_free,
		res_valid |-> (!out_valid || !out_stall),
		"result overwrites held transfer")
	`PSFP_ASSERT(a_stall_only_on_blocked_out,
		in_stall |-> (out_valid && out_stall),
		"input stalled without output backpressure")
	`PSFP_ASSERT(a_failed_frame_zero,
		(out_valid && status != psfp_pkg::STATUS_OK) |->
			(pm1_value == 16'h0000 && pm25_value == 16'h0000 && pm10_value == 16'h0000),
		"failed frame carries PM data")
	`PSFP_ASSERT_ALWAYS(a_reset_no_output,
		!arst_n |=> !out_valid,
		"output valid during reset")

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;

	localparam int HOLD_CYCLES  = 300;
	localparam int QUIET_LIMIT  = 2000;
	localparam int TAIL_CYCLES  = 8;

	typedef enum int {
		FRAME_GOOD,
		FRAME_BAD_HEADER,
		FRAME_BAD_LENGTH,
		FRAME_BAD_CSUM,
		FRAME_CUT,
		FRAME_NOISE
	} frame_kind_t;

	class pm_frame_tracker;
		int                pos = 0;
		logic [15:0]       sum = '0;
		logic              hdr_bad = 1'b0;
		logic              len_bad = 1'b0;
		logic [7:0]        len_hi = '0;
		logic [7:0]        csum_hi = '0;
		logic [15:0]       pm1 = '0;
		logic [15:0]       pm25 = '0;
		logic [15:0]       pm10 = '0;
		psfp_pkg::result_t due_readings[$];
		int                mismatches = 0;

		function void take_byte(logic [7:0] b, logic f);
			psfp_pkg::result_t r;
			if (f || pos >= psfp_pkg::FRAME_BYTES)
				pos = 0;
			if (pos == 0) begin
				sum = '0;
				hdr_bad = 1'b0;
				len_bad = 1'b0;
				len_hi = '0;
				csum_hi = '0;
				pm1 = '0;
				pm25 = '0;
				pm10 = '0;
			end
			if (pos < psfp_pkg::FRAME_BYTES - 2)
				sum = sum + 16'(b);
			case (pos)
				psfp_pkg::POS_HDR0:    hdr_bad = (b != psfp_pkg::HDR_FIRST);
				psfp_pkg::POS_HDR1:    if (b != psfp_pkg::HDR_SECOND) hdr_bad = 1'b1;
				psfp_pkg::POS_LEN_HI:  len_hi = b;
				psfp_pkg::POS_LEN_LO:  len_bad = ({len_hi, b} != psfp_pkg::LEN_EXPECT);
				psfp_pkg::POS_PM1_HI:  pm1[15:8] = b;
				psfp_pkg::POS_PM1_LO:  pm1[7:0] = b;
				psfp_pkg::POS_PM25_HI: pm25[15:8] = b;
				psfp_pkg::POS_PM25_LO: pm25[7:0] = b;
				psfp_pkg::POS_PM10_HI: pm10[15:8] = b;
				psfp_pkg::POS_PM10_LO: pm10[7:0] = b;
				default: ;
			endcase
			if (pos == psfp_pkg::FRAME_BYTES - 2)
				csum_hi = b;
			if (pos == psfp_pkg::FRAME_BYTES - 1) begin
				if (hdr_bad)
					r.status = psfp_pkg::STATUS_BAD_HEADER;
				else if (len_bad)
					r.status = psfp_pkg::STATUS_BAD_LENGTH;
				else if ({csum_hi, b} != sum)
					r.status = psfp_pkg::STATUS_BAD_CSUM;
				else
					r.status = psfp_pkg::STATUS_OK;
				r.pm1_value  = (r.status == psfp_pkg::STATUS_OK) ? pm1 : 16'h0;
				r.pm25_value = (r.status == psfp_pkg::STATUS_OK) ? pm25 : 16'h0;
				r.pm10_value = (r.status == psfp_pkg::STATUS_OK) ? pm10 : 16'h0;
				due_readings.push_back(r);
				pos = 0;
			end else begin
				pos = pos + 1;
			end
		endfunction

		function int pending();
			return due_readings.size();
		endfunction

		function void compare_field(string name, logic [15:0] want, logic [15:0] got);
			if (got !== want) begin
				$display("%0t: %s expected %0h got %0h", $time, name, want, got);
				mismatches++;
			end
		endfunction

		function void check_reading(logic [1:0] st, logic [15:0] a, logic [15:0] b,
			logic [15:0] c);
			psfp_pkg::result_t want;
			if (due_readings.size() == 0) begin
				$display("%0t: unexpected result status %0h pm1 %0h pm25 %0h pm10 %0h",
					$time, st, a, b, c);
				mismatches++;
				return;
			end
			want = due_readings.pop_front();
			compare_field("status", 16'(want.status), 16'(st));
			compare_field("pm1_value", want.pm1_value, a);
			compare_field("pm25_value", want.pm25_value, b);
			compare_field("pm10_value", want.pm10_value, c);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  byte_value = '0;
	logic        first_byte = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  status;
	logic [15:0] pm1_value;
	logic [15:0] pm25_value;
	logic [15:0] pm10_value;

	pm_frame_tracker tracker = new();

	int         send_idle_pct = 0;
	int         recv_idle_pct = 0;
	int         hold_seq = 0;
	int         bytes_sent = 0;
	logic [7:0] frame_buf [psfp_pkg::FRAME_BYTES];

	particulate_sensor_frame_parser u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.byte_value (byte_value),
		.first_byte (first_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.pm1_value  (pm1_value),
		.pm25_value (pm25_value),
		.pm10_value (pm10_value)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		int hold_seen;
		int hold_left;
		if (arst_n) begin
			if (out_valid && !out_stall)
				tracker.check_reading(status, pm1_value, pm25_value, pm10_value);
			if (hold_seen != hold_seq) begin
				hold_seen = hold_seq;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		int quiet_cycles;
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles > QUIET_LIMIT) begin
			$display("FAIL particulate_sensor_frame_parser");
			$finish;
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic f);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		byte_value <= b;
		first_byte <= f;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		tracker.take_byte(b, f);
		bytes_sent++;
	endtask

	function automatic logic [15:0] pick_word();
		case ($urandom_range(0, 5))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic void fill_frame(input logic [15:0] w1, input logic [15:0] w2,
		input logic [15:0] w3, input int fill);
		frame_buf[0] = psfp_pkg::HDR_FIRST;
		frame_buf[1] = psfp_pkg::HDR_SECOND;
		frame_buf[2] = psfp_pkg::LEN_EXPECT[15:8];
		frame_buf[3] = psfp_pkg::LEN_EXPECT[7:0];
		frame_buf[4] = w1[15:8];
		frame_buf[5] = w1[7:0];
		frame_buf[6] = w2[15:8];
		frame_buf[7] = w2[7:0];
		frame_buf[8] = w3[15:8];
		frame_buf[9] = w3[7:0];
		for (int i = 10; i < psfp_pkg::FRAME_BYTES - 2; i++)
			frame_buf[i] = (fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill);
	endfunction

	function automatic void seal_frame();
		logic [15:0] s;
		s = '0;
		for (int i = 0; i < psfp_pkg::FRAME_BYTES - 2; i++)
			s = s + 16'(frame_buf[i]);
		frame_buf[psfp_pkg::FRAME_BYTES-2] = s[15:8];
		frame_buf[psfp_pkg::FRAME_BYTES-1] = s[7:0];
	endfunction

	task automatic send_frame(input int count, input logic first_flag);
		for (int i = 0; i < count; i++)
			send_byte(frame_buf[i], (i == 0) ? first_flag : 1'b0);
	endtask

	task automatic drain_readings();
		in_valid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic directed_frames();
		fill_frame(16'h0000, 16'h0000, 16'h0000, 0);
		seal_frame();
		send_frame(psfp_pkg::FRAME_BYTES, 1'b1);
		// back to back with no first-byte mark
		fill_frame(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
		seal_frame();
		send_frame(psfp_pkg::FRAME_BYTES, 1'b0);
		fill_frame(16'h1234, 16'h5678, 16'h9ABC, -1);
		frame_buf[0] = 8'h00;
		seal_frame();
		send_frame(psfp_pkg::FRAME_BYTES, 1'b1);
		// header and length both wrong: header wins
		fill_frame(16'h0102, 16'h0304, 16'h0506, -1);
		frame_buf[1] = 8'hFF;
		frame_buf[3] = 8'h00;
		seal_frame();
		send_frame(psfp_pkg::FRAME_BYTES, 1'b1);
		fill_frame(pick_word(), pick_word(), pick_word(), -1);
		frame_buf[2] = 8'h01;
		seal_frame();
		send_frame(psfp_pkg::FRAME_BYTES, 1'b1);
		// length and checksum both wrong: length wins
		fill_frame(pick_word(), pick_word(), pick_word(), -1);
		frame_buf[3] = 8'hFF;
		seal_frame();
		frame_buf[psfp_pkg::FRAME_BYTES-1] = ~frame_buf[psfp_pkg::FRAME_BYTES-1];
		send_frame(psfp_pkg::FRAME_BYTES, 1'b1);
		fill_frame(16'hA5A5, 16'h5A5A, 16'h00FF, -1);
		seal_frame();
		frame_buf[psfp_pkg::FRAME_BYTES-2] = ~frame_buf[psfp_pkg::FRAME_BYTES-2];
		send_frame(psfp_pkg::FRAME_BYTES, 1'b1);
		// drop partial frames: one mid-frame, one just before the last byte
		fill_frame(pick_word(), pick_word(), pick_word(), -1);
		seal_frame();
		send_frame(psfp_pkg::FRAME_BYTES / 2, 1'b1);
		send_frame(psfp_pkg::FRAME_BYTES - 1, 1'b1);
		send_frame(psfp_pkg::FRAME_BYTES, 1'b1);
	endtask

	task automatic random_traffic(input int n);
		int          stop;
		int          roll;
		int          idx;
		frame_kind_t kind;
		stop = bytes_sent + n;
		while (bytes_sent < stop) begin
			roll = $urandom_range(0, 99);
			if (roll < 60)
				kind = FRAME_GOOD;
			else if (roll < 68)
				kind = FRAME_BAD_HEADER;
			else if (roll < 74)
				kind = FRAME_BAD_LENGTH;
			else if (roll < 82)
				kind = FRAME_BAD_CSUM;
			else if (roll < 90)
				kind = FRAME_CUT;
			else
				kind = FRAME_NOISE;
			fill_frame(pick_word(), pick_word(), pick_word(), -1);
			case (kind)
				FRAME_BAD_HEADER: begin
					idx = $urandom_range(0, 1);
					frame_buf[idx] = frame_buf[idx] ^ 8'($urandom_range(1, 255));
				end
				FRAME_BAD_LENGTH: begin
					idx = $urandom_range(2, 3);
					frame_buf[idx] = frame_buf[idx] ^ 8'($urandom_range(1, 255));
				end
				default: ;
			endcase
			seal_frame();
			if (kind == FRAME_BAD_CSUM) begin
				idx = $urandom_range(4, psfp_pkg::FRAME_BYTES - 1);
				frame_buf[idx] = frame_buf[idx] ^ 8'($urandom_range(1, 255));
			end
			case (kind)
				FRAME_CUT:
					send_frame($urandom_range(1, psfp_pkg::FRAME_BYTES - 1), 1'b1);
				FRAME_NOISE:
					repeat ($urandom_range(1, 8))
						send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
				default:
					send_frame(psfp_pkg::FRAME_BYTES, ($urandom_range(0, 3) != 0));
			endcase
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 18;
		recv_idle_pct = 52;
		directed_frames();
		random_traffic(430);
		drain_readings();

		send_idle_pct = 52;
		recv_idle_pct = 18;
		random_traffic(430);
		drain_readings();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_seq <= hold_seq + 1;
		random_traffic(440);
		in_valid <= 1'b0;

		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (tracker.mismatches == 0)
			$display("PASS particulate_sensor_frame_parser");
		else
			$display("FAIL particulate_sensor_frame_parser");
		$finish;
	end

endmodule
